// ===== sv/pmt_pkg.sv =====
package pmt_pkg;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int RULE_W    = 16;
  localparam int KEY_SHIFT = 16;
  localparam int CFG_W     = 13;
  localparam int ADDR_W    = 2;

  // Register map
  localparam logic [ADDR_W-1:0] REG_TABLE_ENTRIES = 2'd0;
  localparam logic [CFG_W-1:0]  TABLE_ENTRIES_RST = 13'd4096;

  // Request operations
  localparam logic [1:0] OP_LOOKUP     = 2'd0;
  localparam logic [1:0] OP_STORE_SUCC = 2'd1;
  localparam logic [1:0] OP_STORE_FAIL = 2'd2;

  // Lookup answers, also the stored outcome codes
  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_SUCC = 2'd1;
  localparam logic [1:0] STAT_FAIL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_MATCH,
    S_WRITE,
    S_DELIVER
  } state_t;

endpackage

// ===== sv/pmt_mod_unit.sv =====
module pmt_mod_unit #(
  parameter int KEY_W = 48,
  parameter int MW    = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [MW-1:0]    modulus,
  output logic             done,
  output logic [MW-1:0]    rem
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] shreg;
  logic [MW-1:0]    m_q;
  logic [MW:0]      trial;
  logic [MW:0]      diff;
  logic [MW-1:0]    rem_next;

  // Restoring remainder: one key bit per cycle, MSB first
  always_comb begin
    trial = {rem, shreg[KEY_W-1]};
    diff  = trial - {1'b0, m_q};
    if (trial >= {1'b0, m_q}) begin
      rem_next = diff[MW-1:0];
    end else begin
      rem_next = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(KEY_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= key;
      rem   <= '0;
      m_q   <= modulus;
    end else if (running) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
    end
  end

endmodule

// ===== sv/pmt_slot_ram.sv =====
module pmt_slot_ram #(
  parameter int DEPTH  = 4096,
  parameter int WORD_W = 115
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_W-1:0]        rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/packrat_memo_table.sv =====
// Packrat memo table: a direct-mapped store of parse outcomes keyed by
// (position, rule_point).
//
// Request channel (in_valid/in_ready) carries op, position, rule_point,
// consumed_in and tree_in. Every request yields exactly one result beat on
// the result channel (out_valid/out_ready): status, consumed_out, tree_out.
// Stores and unused ops answer all zeros; a lookup answers the stored entry
// when its full key matches, else "not found".
//
// The slot is key mod table_entries (clamped to 1..MAX_SLOTS), computed by
// a one-bit-a-cycle remainder unit over the KEY_W = min(POS_WIDTH,32)+16
// key bits; a lookup then reads the slot and matches keys, a store writes
// the slot. One request is in work at a time; the next is accepted once the
// current result sits in the output register, even while it waits there.
//
// Reset: rst (synchronous) restores table_entries to 4096 and starts a
// clearing pass that writes every slot empty, one per cycle; in_ready
// stays low until it finishes. APB writes are taken whenever rst is low.
// A stalled receiver holds the result beat steady; the block then
// finishes at most one more request and waits for the output register.
module packrat_memo_table
  import pmt_pkg::*;
#(
  parameter int MAX_SLOTS = 4096,
  parameter int POS_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [DATA_W-1:0] position,
  input  logic [RULE_W-1:0] rule_point,
  input  logic [DATA_W-1:0] consumed_in,
  input  logic [DATA_W-1:0] tree_in,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] consumed_out,
  output logic [DATA_W-1:0] tree_out,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Only the low min(POS_WIDTH, DATA_W) bits of position reach the key
  localparam int PW    = (POS_WIDTH < DATA_W) ? POS_WIDTH : DATA_W;
  localparam int KEY_W = PW + KEY_SHIFT;
  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int MW    = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [1:0]       outcome;
    logic [DATA_W-1:0] consumed;
    logic [DATA_W-1:0] tree;
  } slot_word_t;

  localparam int WORD_W = $bits(slot_word_t);

  state_t state, state_next;

  logic [CFG_W-1:0]  table_entries;
  logic [MW-1:0]     modulus;
  logic [KEY_W-1:0]  key_in;

  // held request
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] consumed_q;
  logic [DATA_W-1:0] tree_q;
  logic [AW-1:0]     slot_q;

  // result waiting for the output register
  logic [1:0]        res_status;
  logic [DATA_W-1:0] res_consumed;
  logic [DATA_W-1:0] res_tree;

  logic [AW-1:0]     clr_idx;
  logic              clr_last;

  logic              in_fire;
  logic              div_done;
  logic [MW-1:0]     div_rem;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_word_t        wr_word;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;
  slot_word_t        rd_word;
  logic              hit;
  logic              out_load;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries <= TABLE_ENTRIES_RST;
    end else if (psel && penable && pwrite && paddr == REG_TABLE_ENTRIES) begin
      table_entries <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr == REG_TABLE_ENTRIES) begin
      prdata = {{(DATA_W-CFG_W){1'b0}}, table_entries};
    end else begin
      prdata = '0;
    end
  end

  // Zero size behaves as one slot; anything past the array is clamped
  always_comb begin
    if (table_entries == '0) begin
      modulus = MW'(1);
    end else if (32'(table_entries) > MAX_SLOTS) begin
      modulus = MW'(MAX_SLOTS);
    end else begin
      modulus = MW'(table_entries);
    end
  end

  assign key_in  = {position[PW-1:0], rule_point};
  assign in_fire = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Slot index: key mod table size
  // ---------------------------------------------------------------------
  pmt_mod_unit #(
    .KEY_W (KEY_W),
    .MW    (MW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire),
    .key     (key_in),
    .modulus (modulus),
    .done    (div_done),
    .rem     (div_rem)
  );

  // ---------------------------------------------------------------------
  // Slot store
  // ---------------------------------------------------------------------
  pmt_slot_ram #(
    .DEPTH  (MAX_SLOTS),
    .WORD_W (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (slot_q),
    .rdata (ram_rdata)
  );

  assign rd_word = slot_word_t'(ram_rdata);
  assign hit     = rd_word.valid && (rd_word.key == key_q);
  assign clr_last = (clr_idx == AW'(MAX_SLOTS - 1));

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) begin
          priority if (op_q == OP_LOOKUP) begin
            state_next = S_READ;
          end else if (op_q == OP_STORE_SUCC || op_q == OP_STORE_FAIL) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_DELIVER;
          end
        end
      end
      S_READ:    state_next = S_MATCH;
      S_MATCH:   state_next = S_DELIVER;
      S_WRITE:   state_next = S_DELIVER;
      S_DELIVER: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = slot_q;
    ram_re           = 1'b0;
    out_load         = 1'b0;
    wr_word          = '0;
    wr_word.valid    = 1'b1;
    wr_word.key      = key_q;
    wr_word.tree     = tree_q;
    if (op_q == OP_STORE_SUCC) begin
      wr_word.outcome  = STAT_SUCC;
      wr_word.consumed = consumed_q;
    end else begin
      wr_word.outcome  = STAT_FAIL;
      wr_word.consumed = '0;
    end
    unique case (state)
      S_CLEAR: begin
        // write the slot empty
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        wr_word   = '0;
      end
      S_IDLE:    in_ready = 1'b1;
      S_DIVIDE:  ;
      S_READ:    ram_re = 1'b1;
      S_MATCH:   ;
      S_WRITE:   ram_we = 1'b1;
      S_DELIVER: out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

  // Hold the request while it is in work
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q       <= op;
      key_q      <= key_in;
      consumed_q <= consumed_in;
      tree_q     <= tree_in;
    end
    if (state == S_DIVIDE && div_done) begin
      slot_q <= div_rem[AW-1:0];
    end
  end

  // Form the answer: stored entry on a key match, zeros otherwise
  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      if (hit) begin
        res_status   <= rd_word.outcome;
        res_consumed <= rd_word.consumed;
        res_tree     <= rd_word.tree;
      end else begin
        res_status   <= STAT_NONE;
        res_consumed <= '0;
        res_tree     <= '0;
      end
    end else if (state == S_DIVIDE && div_done) begin
      res_status   <= STAT_NONE;
      res_consumed <= '0;
      res_tree     <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold the beat until the receiver takes it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      consumed_out <= res_consumed;
      tree_out     <= res_tree;
    end
  end

endmodule

// ===== sv/pmt_checker.sv =====
module pmt_checker
  import pmt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        status,
  input logic [DATA_W-1:0] consumed_out,
  input logic [DATA_W-1:0] tree_out
);

  // Result beat stays up while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(status) && $stable(consumed_out) && $stable(tree_out))
    else $error("result payload changed while stalled");

  // Clearing pass follows reset: no request taken, no result shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block active right after reset");

  // Status codes stay in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_NONE || status == STAT_SUCC || status == STAT_FAIL))
    else $error("undefined status code");

  // Misses and failure hits carry no consumed length
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FAIL || status == STAT_NONE) |-> consumed_out == '0)
    else $error("consumed length on a miss or failure");

endmodule

bind packrat_memo_table pmt_checker u_pmt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .consumed_out (consumed_out),
  .tree_out     (tree_out)
);
